FILE: rtl/core/jccs_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// jccs_pkg
// Shared types, character constants and helper functions for the JSONC
// comment and trailing comma stripper.
// ============================================================================
package jccs_pkg;

    // Character codes the lexer reacts to.
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // Whitespace codes kept in the whitespace memory.
    localparam logic [1:0] WS_SPACE = 2'd0;
    localparam logic [1:0] WS_TAB   = 2'd1;
    localparam logic [1:0] WS_CR    = 2'd2;
    localparam logic [1:0] WS_LF    = 2'd3;

    // Output phases, in the order in which one input byte emits them.
    // The controller state uses the same codes.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_COMMA = 3'd2;
    localparam logic [2:0] PH_SPACE = 3'd3;
    localparam logic [2:0] PH_CHAR  = 3'd4;
    localparam logic [2:0] PH_MARK  = 3'd5;

    // Which phases one input byte needs.
    typedef struct packed {
        logic pre;     // pending slash released
        logic comma;   // held comma released
        logic has_sp;  // held whitespace released
        logic chr;     // the input byte itself
        logic mark;    // bare end marker
    } plan_t;

    // Controller to datapath.
    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [2:0] kind;
        logic       final_item;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        plan_t plan_in;
        plan_t plan_held;
        logic  sp_last;
        logic  can_load;
    } status_t;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    function automatic logic [1:0] ws_code(input logic [7:0] c);
        logic [1:0] code;
        case (c)
            CH_TAB:  code = WS_TAB;
            CH_CR:   code = WS_CR;
            CH_LF:   code = WS_LF;
            default: code = WS_SPACE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] ws_char(input logic [1:0] code);
        logic [7:0] c;
        case (code)
            WS_TAB:  c = CH_TAB;
            WS_CR:   c = CH_CR;
            WS_LF:   c = CH_LF;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

    // First phase of the plan that comes after phase ph.
    function automatic logic [2:0] next_phase(input plan_t p, input logic [2:0] ph);
        logic [2:0] nxt;
        if (ph < PH_PRE && p.pre) begin
            nxt = PH_PRE;
        end else if (ph < PH_COMMA && p.comma) begin
            nxt = PH_COMMA;
        end else if (ph < PH_SPACE && p.has_sp) begin
            nxt = PH_SPACE;
        end else if (ph < PH_CHAR && p.chr) begin
            nxt = PH_CHAR;
        end else if (ph < PH_MARK && p.mark) begin
            nxt = PH_MARK;
        end else begin
            nxt = PH_IDLE;
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/core/jccs_if.sv
`timescale 1ns / 1ps
// ============================================================================
// jccs_if
// Valid/ready stream interfaces for the raw text input and the stripped
// output of the stripper.
// ============================================================================
interface jccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface jccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       text_end;

    modport source (
        output valid, output out_byte, output byte_valid,
        output last_of_run, output text_end, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid,
        input last_of_run, input text_end, output ready
    );
endinterface

FILE: rtl/core/jccs_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// jccs_ctrl
// Output sequencer: walks the phases that one input byte needs and hands
// one result a cycle to the datapath's output register when it can load.
// ============================================================================
module jccs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  jccs_pkg::status_t status,
    output jccs_pkg::cmd_t    cmd
);
    import jccs_pkg::*;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] first_ph;
    logic [2:0] after_ph;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Phase sequencing. In idle the first result is loaded in the accept cycle
    // if the output can load and it is not whitespace (that needs a memory read).
    always_comb
    begin
        in_ready       = (state_reg == PH_IDLE);
        cmd.accept     = in_valid && in_ready;
        cmd.emit       = 1'b0;
        cmd.kind       = state_reg;
        cmd.final_item = 1'b0;
        state_next     = state_reg;
        first_ph       = next_phase(status.plan_in, PH_IDLE);
        after_ph       = PH_IDLE;
        if (state_reg == PH_IDLE)
        begin
            if (cmd.accept && first_ph != PH_IDLE)
            begin
                cmd.kind = first_ph;
                if (first_ph != PH_SPACE && status.can_load)
                begin
                    after_ph       = next_phase(status.plan_in, first_ph);
                    cmd.emit       = 1'b1;
                    cmd.final_item = (after_ph == PH_IDLE);
                    state_next     = after_ph;
                end
                else
                begin
                    state_next = first_ph;
                end
            end
        end
        else if (status.can_load)
        begin
            cmd.emit = 1'b1;
            if (state_reg == PH_SPACE && !status.sp_last)
            begin
                state_next = state_reg;
            end
            else
            begin
                after_ph       = next_phase(status.plan_held, state_reg);
                cmd.final_item = (after_ph == PH_IDLE);
                state_next     = after_ph;
            end
        end
    end

endmodule

FILE: rtl/core/jccs_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// jccs_datapath
// Lexer state, whitespace memory, per-byte plan and the output register.
// ============================================================================
module jccs_datapath #(
    parameter int WS_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  logic              is_last,
    input  jccs_pkg::cmd_t    cmd,
    output jccs_pkg::status_t status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              last_of_run,
    output logic              text_end
);
    import jccs_pkg::*;

    localparam int CW = $clog2(WS_DEPTH + 1);
    localparam int AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(WS_DEPTH);

    // Lexer modes.
    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_STRING = 3'd1;
    localparam logic [2:0] M_ESCAPE = 3'd2;
    localparam logic [2:0] M_SLASH  = 3'd3;
    localparam logic [2:0] M_LINE   = 3'd4;
    localparam logic [2:0] M_BLOCK  = 3'd5;
    localparam logic [2:0] M_STAR   = 3'd6;

    logic [2:0]    mode_reg;
    logic [2:0]    mode_next;
    logic          comma_reg;
    logic          comma_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          wr_en;
    logic          do_norm;
    logic          handled;
    plan_t         plan_in;
    logic [CW-1:0] nsp_in;

    plan_t         plan_held_reg;
    logic [CW-1:0] nsp_reg;
    logic [7:0]    byte_reg;
    logic          last_reg;

    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;
    logic [AW-1:0] rd_addr;
    logic [1:0]    rd_data_reg;
    logic [1:0]    ws_mem [WS_DEPTH];

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          byte_valid_reg;
    logic          last_of_run_reg;
    logic          text_end_reg;
    logic [7:0]    emit_byte;
    logic          emit_last;

    // Plan for the byte on the input and the lexer's next state.
    always_comb
    begin
        mode_next  = mode_reg;
        comma_next = comma_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        do_norm    = 1'b0;
        handled    = 1'b0;
        plan_in    = '0;
        nsp_in     = '0;
        case (mode_reg)
            M_STRING:
            begin
                plan_in.chr = 1'b1;
                if (in_byte == CH_BSLASH)
                begin
                    mode_next = M_ESCAPE;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    mode_next = M_NORMAL;
                end
            end
            M_ESCAPE:
            begin
                plan_in.chr = 1'b1;
                mode_next   = M_STRING;
            end
            M_SLASH:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = M_LINE;
                end
                else if (in_byte == CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
                else
                begin
                    plan_in.pre = 1'b1;
                    mode_next   = M_NORMAL;
                    do_norm     = 1'b1;
                end
            end
            M_LINE:
            begin
                if (in_byte == CH_LF)
                begin
                    plan_in.chr = 1'b1;
                    mode_next   = M_NORMAL;
                end
            end
            M_BLOCK:
            begin
                if (in_byte == CH_STAR)
                begin
                    mode_next = M_STAR;
                end
            end
            M_STAR:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = M_NORMAL;
                end
                else if (in_byte != CH_STAR)
                begin
                    mode_next = M_BLOCK;
                end
            end
            default:
            begin
                mode_next = M_NORMAL;
                do_norm   = 1'b1;
            end
        endcase

        // Normal text: held comma handling, then the byte itself.
        if (do_norm)
        begin
            if (comma_reg)
            begin
                if (is_ws(in_byte))
                begin
                    handled = 1'b1;
                    if (cnt_reg < DEPTH_C)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        plan_in.comma = 1'b1;
                        plan_in.chr   = 1'b1;
                        nsp_in        = cnt_reg;
                        comma_next    = 1'b0;
                        cnt_next      = '0;
                    end
                end
                else if (in_byte inside {CH_RBRACE, CH_RBRACKET})
                begin
                    handled     = 1'b1;
                    plan_in.chr = 1'b1;
                    nsp_in      = cnt_reg;
                    comma_next  = 1'b0;
                    cnt_next    = '0;
                end
                else
                begin
                    plan_in.comma = 1'b1;
                    nsp_in        = cnt_reg;
                    comma_next    = 1'b0;
                    cnt_next      = '0;
                end
            end
            if (!handled)
            begin
                if (in_byte == CH_QUOTE)
                begin
                    plan_in.chr = 1'b1;
                    mode_next   = M_STRING;
                end
                else if (in_byte == CH_SLASH)
                begin
                    mode_next = M_SLASH;
                end
                else if (in_byte == CH_COMMA)
                begin
                    comma_next = 1'b1;
                    cnt_next   = '0;
                end
                else
                begin
                    plan_in.chr = 1'b1;
                end
            end
        end

        // End of text. A pending slash or a held comma is the input byte
        // itself; whitespace just taken in also goes out as the byte.
        if (is_last)
        begin
            if (mode_next == M_SLASH)
            begin
                plan_in.chr = 1'b1;
            end
            if (comma_next)
            begin
                plan_in.chr = 1'b1;
                if (wr_en)
                begin
                    plan_in.comma = 1'b1;
                    nsp_in        = cnt_reg;
                end
            end
            mode_next  = M_NORMAL;
            comma_next = 1'b0;
            cnt_next   = '0;
            wr_en      = 1'b0;
        end
        plan_in.has_sp = (nsp_in != '0);
        plan_in.mark   = is_last && !(plan_in.pre || plan_in.comma
                                      || plan_in.has_sp || plan_in.chr);
    end

    // Lexer state and the plan of the accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_NORMAL;
            comma_reg     <= 1'b0;
            cnt_reg       <= '0;
            plan_held_reg <= '0;
        end
        else if (cmd.accept)
        begin
            mode_reg      <= mode_next;
            comma_reg     <= comma_next;
            cnt_reg       <= cnt_next;
            plan_held_reg <= plan_in;
        end
    end

    // Payload of the accepted byte.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            nsp_reg  <= nsp_in;
            byte_reg <= in_byte;
            last_reg <= is_last;
        end
    end

    // Read index into the held whitespace; back to zero after each run.
    always_comb
    begin
        if (cmd.emit && cmd.final_item)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.accept)
        begin
            rd_idx_next = '0;
        end
        else if (cmd.emit && cmd.kind == PH_SPACE)
        begin
            rd_idx_next = rd_idx_reg + CW'(1);
        end
        else
        begin
            rd_idx_next = rd_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign rd_addr = rd_idx_next[AW-1:0];

    // Whitespace memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            ws_mem[cnt_reg[AW-1:0]] <= ws_code(in_byte);
        end
        rd_data_reg <= ws_mem[rd_addr];
    end

    // Byte for the result being loaded.
    always_comb
    begin
        case (cmd.kind)
            PH_PRE:   emit_byte = CH_SLASH;
            PH_COMMA: emit_byte = CH_COMMA;
            PH_SPACE: emit_byte = ws_char(rd_data_reg);
            PH_CHAR:  emit_byte = cmd.accept ? in_byte : byte_reg;
            default:  emit_byte = 8'h00;
        endcase
        emit_last = cmd.accept ? is_last : last_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg    <= emit_byte;
            byte_valid_reg  <= (cmd.kind != PH_MARK);
            last_of_run_reg <= cmd.final_item;
            text_end_reg    <= cmd.final_item && emit_last;
        end
    end

    // Status to the controller.
    always_comb
    begin
        status.plan_in   = plan_in;
        status.plan_held = plan_held_reg;
        status.sp_last   = (CW'(rd_idx_reg + CW'(1)) == nsp_reg);
        status.can_load  = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign last_of_run = last_of_run_reg;
    assign text_end    = text_end_reg;

endmodule

FILE: rtl/core/jsonc_comment_comma_stripper.sv
`timescale 1ns / 1ps
// ============================================================================
// jsonc_comment_comma_stripper
// Strips comments and trailing commas from JSONC text, one byte a transfer.
// ============================================================================
//
//   Port     Dir  Payload                                       Transfer
//   in_ch    in   in_byte[7:0], is_last                         valid && ready
//   out_ch   out  out_byte[7:0], byte_valid, last_of_run,       valid && ready
//                 text_end
//
// An input byte's results are loaded into the output register one after
// another; when its first result is held whitespace, a read of the
// whitespace memory's registered read port goes first.
// A byte that gives no result (comment text, held whitespace) leaves the input
// ready. Output stalls hold the sequencer; the output register frees the input
// side as soon as the last result of a byte is loaded.
// Reset (rst_n, asynchronous) returns the lexer to normal text with no comma
// held; the whitespace memory needs no clearing.
//
module jsonc_comment_comma_stripper #(
    parameter int WS_DEPTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    jccs_in_if.sink         in_ch,
    jccs_out_if.source      out_ch
);
    import jccs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    jccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Lexer, whitespace memory and output register.
    jccs_datapath #(
        .WS_DEPTH (WS_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_ch.in_byte),
        .is_last     (in_ch.is_last),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_byte    (out_ch.out_byte),
        .byte_valid  (out_ch.byte_valid),
        .last_of_run (out_ch.last_of_run),
        .text_end    (out_ch.text_end)
    );

endmodule

FILE: rtl/core/jccs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// jccs_checker
// Port-level checks on the stripper's streams, bound to the top level.
// ============================================================================
module jccs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       last_of_run,
    input logic       text_end
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(last_of_run) && $stable(text_end))
        else $error("stalled result changed");

    // The end of the text always closes a run.
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> last_of_run)
        else $error("text_end without last_of_run");

    // A bare marker carries a zero byte and only ever ends the text.
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> out_byte == 8'h00 && text_end)
        else $error("malformed end marker");

    // No new byte is taken while the current byte still has results to give.
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken in the middle of a run");

endmodule

bind jsonc_comment_comma_stripper jccs_checker u_jccs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .last_of_run (out_ch.last_of_run),
    .text_end    (out_ch.text_end)
);

FILE: sim/tb_jsonc_comment_comma_stripper.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_jsonc_comment_comma_stripper
// Self-checking testbench for the JSONC comment and trailing comma stripper.
// Byte streams go in through the input channel. A behavioral predictor works
// out the JSON bytes and end markers that each accepted byte must produce,
// and every output transfer is checked against the oldest of them. Short
// directed texts come first, then a backpressure run that fills the block,
// then randomly built JSONC texts with random idling on both channels.
// ============================================================================
module tb_jsonc_comment_comma_stripper;

    import jccs_pkg::*;

    localparam int WS_DEPTH     = 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 64;

    // Lexer modes of the predictor.
    typedef enum logic [2:0] {
        LX_NORMAL,
        LX_STRING,
        LX_ESCAPE,
        LX_SLASH,
        LX_LINE,
        LX_BLOCK,
        LX_STAR
    } lex_mode_e;

    // One output transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       text_end;
    } json_out_t;

    logic clk;
    logic rst_n;

    jccs_in_if  in_ch ();
    jccs_out_if out_ch ();

    jsonc_comment_comma_stripper #(
        .WS_DEPTH (WS_DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state.
    lex_mode_e  lx_mode;
    logic       comma_open;
    logic [7:0] held_ws[$];
    json_out_t  step_run[$];
    json_out_t  json_expect_q[$];

    // Text under construction.
    logic [7:0] text_buf[$];

    // Idling controls and run statistics.
    bit src_idle;
    bit rx_idle;
    int rx_stall_left;
    int rx_hold_left;
    int items_sent;
    int texts_sent;
    int results_seen;
    int mismatches;
    int cycle_count;

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------
    function automatic void add_out(input logic [7:0] c);
        json_out_t r;
        r.out_byte    = c;
        r.byte_valid  = 1'b1;
        r.last_of_run = 1'b0;
        r.text_end    = 1'b0;
        step_run.insert(step_run.size(), r);
    endfunction

    // A released comma is followed by the whitespace held behind it.
    function automatic void release_comma();
        add_out(CH_COMMA);
        foreach (held_ws[k])
        begin
            add_out(held_ws[k]);
        end
        held_ws.delete();
        comma_open = 1'b0;
    endfunction

    // Handling of one byte outside strings and comments.
    function automatic void plain_step(input logic [7:0] c);
        if (comma_open)
        begin
            if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})
            begin
                if (held_ws.size() < WS_DEPTH)
                begin
                    held_ws.insert(held_ws.size(), c);
                end
                else
                begin
                    release_comma();
                    add_out(c);
                end
                return;
            end
            if (c == CH_RBRACE || c == CH_RBRACKET)
            begin
                // Trailing comma: drop it but keep its whitespace.
                comma_open = 1'b0;
                foreach (held_ws[k])
                begin
                    add_out(held_ws[k]);
                end
                held_ws.delete();
                add_out(c);
                return;
            end
            release_comma();
        end
        if (c == CH_QUOTE)
        begin
            add_out(c);
            lx_mode = LX_STRING;
        end
        else if (c == CH_SLASH)
        begin
            lx_mode = LX_SLASH;
        end
        else if (c == CH_COMMA)
        begin
            comma_open = 1'b1;
            held_ws.delete();
        end
        else
        begin
            add_out(c);
        end
    endfunction

    // Works out every transfer caused by one accepted input byte.
    function automatic void strip_predict(input logic [7:0] c, input logic eot);
        json_out_t marker;
        step_run.delete();
        case (lx_mode)
            LX_STRING:
            begin
                add_out(c);
                if (c == CH_BSLASH)
                begin
                    lx_mode = LX_ESCAPE;
                end
                else if (c == CH_QUOTE)
                begin
                    lx_mode = LX_NORMAL;
                end
            end
            LX_ESCAPE:
            begin
                add_out(c);
                lx_mode = LX_STRING;
            end
            LX_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    lx_mode = LX_LINE;
                end
                else if (c == CH_STAR)
                begin
                    lx_mode = LX_BLOCK;
                end
                else
                begin
                    add_out(CH_SLASH);
                    lx_mode = LX_NORMAL;
                    plain_step(c);
                end
            end
            LX_LINE:
            begin
                if (c == CH_LF)
                begin
                    add_out(c);
                    lx_mode = LX_NORMAL;
                end
            end
            LX_BLOCK:
            begin
                if (c == CH_STAR)
                begin
                    lx_mode = LX_STAR;
                end
            end
            LX_STAR:
            begin
                if (c == CH_SLASH)
                begin
                    lx_mode = LX_NORMAL;
                end
                else if (c != CH_STAR)
                begin
                    lx_mode = LX_BLOCK;
                end
            end
            default:
            begin
                lx_mode = LX_NORMAL;
                plain_step(c);
            end
        endcase

        // End of text flushes whatever is held and returns to normal text.
        if (eot)
        begin
            if (lx_mode == LX_SLASH)
            begin
                add_out(CH_SLASH);
            end
            if (comma_open)
            begin
                release_comma();
            end
            lx_mode    = LX_NORMAL;
            comma_open = 1'b0;
            held_ws.delete();
            if (step_run.size() == 0)
            begin
                marker = '0;
                step_run.insert(step_run.size(), marker);
            end
            step_run[step_run.size() - 1].text_end = 1'b1;
        end
        if (step_run.size() > 0)
        begin
            step_run[step_run.size() - 1].last_of_run = 1'b1;
        end
        foreach (step_run[k])
        begin
            json_expect_q.insert(json_expect_q.size(), step_run[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic int draw_wait(input bit on);
        return on ? int'($urandom_range(0, 14)) : 0;
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] any_ws();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_SPACE;
            1:       c = CH_TAB;
            2:       c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

    // Appends one byte to the text under construction.
    function automatic void put_byte(input logic [7:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    function automatic void put_str(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            put_byte(s[k]);
        end
    endfunction

    // Appends one JSONC token: mostly well-formed pieces with random content.
    function automatic void put_token();
        logic [7:0] c;
        case ($urandom_range(0, 13))
            0, 1:
            begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 5) == 0)
                    begin
                        put_byte(CH_BSLASH);
                        put_byte(any_byte());
                    end
                    else
                    begin
                        c = 8'($urandom_range(8'h20, 8'h7E));
                        if (c == CH_QUOTE || c == CH_BSLASH)
                        begin
                            c = 8'h61;
                        end
                        put_byte(c);
                    end
                end
                put_byte(CH_QUOTE);
            end
            2: put_str("{");
            3: put_str("[");
            4: put_byte(CH_RBRACE);
            5: put_byte(CH_RBRACKET);
            6, 7:
            begin
                // Comma with a whitespace run, sometimes long enough to overflow.
                put_byte(CH_COMMA);
                repeat (($urandom_range(0, 3) == 0) ? $urandom_range(14, 18)
                                                    : $urandom_range(0, 4))
                begin
                    put_byte(any_ws());
                end
                case ($urandom_range(0, 3))
                    0: put_byte(CH_RBRACE);
                    1: put_byte(CH_RBRACKET);
                    default: ;
                endcase
            end
            8:
            begin
                put_str("//");
                repeat ($urandom_range(0, 6))
                begin
                    c = any_byte();
                    put_byte((c == CH_LF) ? CH_SPACE : c);
                end
                put_byte(CH_LF);
            end
            9:
            begin
                put_str("/*");
                repeat ($urandom_range(0, 6))
                begin
                    put_byte(($urandom_range(0, 2) == 0) ? CH_STAR : any_byte());
                end
                put_str("*/");
            end
            10: put_byte(CH_SLASH);
            11: put_byte(any_byte());
            12: put_byte(any_ws());
            default:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    put_byte(8'($urandom_range(8'h30, 8'h7A)));
                end
            end
        endcase
    endfunction

    // Sends one byte and records its expected results once it is accepted.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        gap = draw_wait(src_idle);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= c;
        in_ch.is_last <= eot;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        strip_predict(c, eot);
        items_sent++;
    endtask

    // Sends the text buffer with the end mark on its final byte.
    task automatic send_text();
        foreach (text_buf[k])
        begin
            send_byte(text_buf[k], k == text_buf.size() - 1);
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;
        texts_sent++;
        text_buf.delete();
    endtask

    task automatic wait_drained();
        while (json_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Strings with escapes, both comment kinds, trailing comma, and the
    // end-of-text cases: pending slash, held comma, abandoned string and a
    // final byte that produces nothing.
    task automatic run_directed_text();
        put_str("\"\\\"/,\"");
        put_str(", ]");
        put_byte(8'hFF);
        put_str("//x\n");
        send_text();
        // Opener star does not close; lone slash after comma; comma after comma.
        put_str("/*/*/,/x,,/");
        send_text();
        put_byte(8'h00);
        send_text();
        put_str("/*");
        send_text();
        put_byte(CH_QUOTE);
        put_byte(8'h80);
        send_text();
        put_str(",\t");
        send_text();
        wait_drained();
    endtask

    // The receiver holds off while full whitespace runs keep arriving, so
    // the block fills and stalls its input; afterwards the sender waits for
    // every result before going on.
    task automatic run_stall_fill();
        src_idle     = 1'b0;
        rx_hold_left = 300;
        for (int k = 0; k < 3; k++)
        begin
            put_byte(CH_COMMA);
            repeat (WS_DEPTH + (k % 2))
            begin
                put_byte(any_ws());
            end
            put_str("a");
        end
        put_str(",  ]\"q\",");
        send_text();
        wait_drained();
    endtask

    // Random JSONC texts, a few of pure noise, with idling switched in and
    // out in stretches.
    task automatic run_random_jsonc();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                src_idle = !src_idle;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                rx_idle = !rx_idle;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    put_byte(any_byte());
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10))
                begin
                    put_token();
                end
            end
            send_text();
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Output receiver: random stalls per transfer plus long hold-offs.
    // ------------------------------------------------------------------
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_hold_left--;
            end
            else if (rx_stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker.
    // ------------------------------------------------------------------
    initial
    begin : out_check
        json_out_t got;
        json_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.out_byte    = out_ch.out_byte;
                got.byte_valid  = out_ch.byte_valid;
                got.last_of_run = out_ch.last_of_run;
                got.text_end    = out_ch.text_end;
                results_seen++;
                rx_stall_left = draw_wait(rx_idle);
                if (json_expect_q.size() == 0)
                begin
                    $error("unexpected output transfer: out_byte %02h", got.out_byte);
                    mismatches++;
                end
                else
                begin
                    want = json_expect_q.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, got.out_byte);
                        mismatches++;
                    end
                    if (got.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %0b, got %0b",
                               want.byte_valid, got.byte_valid);
                        mismatches++;
                    end
                    if (got.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last_of_run, got.last_of_run);
                        mismatches++;
                    end
                    if (got.text_end !== want.text_end)
                    begin
                        $error("text_end: expected %0b, got %0b",
                               want.text_end, got.text_end);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles.", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.is_last = 1'b0;
        lx_mode       = LX_NORMAL;
        comma_open    = 1'b0;
        src_idle      = 1'b1;
        rx_idle       = 1'b1;
        rx_stall_left = 0;
        rx_hold_left  = 0;
        items_sent    = 0;
        texts_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed_text();
        run_stall_fill();
        run_random_jsonc();

        wait_drained();
        rx_idle = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d texts (%0d bytes) and checked %0d output transfers.",
                 texts_sent, items_sent, results_seen);
        $display("Covered strings, comments, trailing commas, long whitespace runs ",
                 "and end-of-text flushes.");
        if (mismatches == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/jccs_pkg.sv
rtl/core/jccs_if.sv
rtl/core/jccs_ctrl.sv
rtl/core/jccs_datapath.sv
rtl/core/jsonc_comment_comma_stripper.sv
rtl/core/jccs_checker.sv
sim/tb_jsonc_comment_comma_stripper.sv
